// ===== hdl/assert_macros.svh =====
// Assertion helpers for the interface adapter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("check failed");
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("check failed");
`else
`define CHK_IMPL(lbl, clk, rst, a, c)
`define CHK_NEXT(lbl, clk, rst, a, c)
`endif
`endif

// ===== hdl/iat_pkg.sv =====
package iat_pkg;
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  localparam logic [3:0] R_PRA = 4'h0, R_PRB = 4'h1, R_DDRA = 4'h2, R_DDRB = 4'h3;
  localparam logic [3:0] R_TAL = 4'h4, R_TAH = 4'h5, R_TBL = 4'h6, R_TBH = 4'h7;
  localparam logic [3:0] R_TOD10 = 4'h8, R_TODS = 4'h9, R_TODM = 4'hA, R_TODH = 4'hB;
  localparam logic [3:0] R_SDR = 4'hC, R_ICR = 4'hD, R_CRA = 4'hE, R_CRB = 4'hF;

  localparam logic [1:0] CFG_KBD = 2'd0;
  localparam logic [1:0] CFG_FRAME = 2'd1;
  localparam logic [15:0] FRAME_RESET = 16'd19656;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  reg_addr;
    logic [7:0]  write_data;
    logic        side_effects;
    logic [63:0] keyboard_matrix;
    logic [7:0]  joystick_one;
    logic [7:0]  joystick_two;
    logic [7:0]  port_a_external;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
    logic [1:0] video_bank;
  } result_t;

  // classified command from the front part
  typedef struct packed {
    logic       is_read;
    logic       is_write;
    logic       is_tick;
    item_t      item;
  } cmd_t;

  typedef struct packed {
    logic [3:0] tenths;
    logic [6:0] sec;
    logic [6:0] min;
    logic [7:0] hour;
  } tod_t;

  function automatic logic [7:0] bcd_next(input logic [7:0] v, input logic [7:0] mx);
    logic [4:0] lo;
    logic [4:0] hi;
    logic [7:0] r;
    lo = {1'b0, v[3:0]} + 5'd1;
    hi = {1'b0, v[7:4]};
    if (lo > 5'd9) begin
      lo = 5'd0;
      hi = hi + 5'd1;
    end
    r = {hi[3:0], lo[3:0]};
    return (r > mx) ? 8'h00 : r;
  endfunction
endpackage

// ===== hdl/iat_stream_if.sv =====
interface iat_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/iat_front.sv =====
module iat_front import iat_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_ready,
  output cmd_t  q_cmd
);
  cmd_t       slot [QUEUE_DEPTH];
  logic       wp, rp;
  logic [1:0] fill;
  cmd_t       c;
  logic       push, pop;

  // classify the beat
  always_comb begin
    c.item = in_item;
    c.is_read = (in_item.func == FUNC_READ);
    c.is_write = (in_item.func == FUNC_WRITE);
    c.is_tick = (in_item.func == FUNC_TICK);
  end

  assign in_ready = (fill != 2'(QUEUE_DEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (fill != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + 2'(push) - 2'(pop);
    end
    if (push) slot[wp] <= c;
  end
endmodule

// ===== hdl/iat_back.sv =====
module iat_back import iat_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_kbd,
  input  logic [15:0] cfg_frame,
  input  logic      q_valid,
  output logic      q_ready,
  input  cmd_t      q_cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_res
);
  logic [7:0] port_a_out, port_b_out, dir_a, dir_b;
  logic [15:0] count_a, reload_a, count_b, reload_b;
  logic [7:0] ctrl_a, ctrl_b, shift_reg;
  logic [4:0] pending_int, int_mask;
  tod_t clock_time, alarm_time, snapshot_time;
  logic snapshot_held, clock_halted;
  logic [18:0] tenth_divider, period;
  logic [3:0] tob;

  logic [7:0] port_a_out_next, port_b_out_next, dir_a_next, dir_b_next;
  logic [15:0] count_a_next, reload_a_next, count_b_next, reload_b_next;
  logic [7:0] ctrl_a_next, ctrl_b_next, shift_reg_next;
  logic [4:0] pending_next, mask_next;
  tod_t clock_next, alarm_next, snap_next;
  logic held_next, halted_next;
  logic [18:0] div_next;
  logic [3:0] tob_next;
  logic [7:0] rd;

  item_t it;
  logic  go;
  logic  ua, ub, cntb, alarm_sel;
  logic [7:0] s8, m8, h8, pm;
  logic [4:0] tplus;

  assign it = q_cmd.item;
  assign q_ready = !out_valid || out_ready;
  assign go = q_valid && q_ready;

  // period = 5 or 6 frames, from the current control bit and frame length
  always_comb begin
    period = ({3'd0, cfg_frame} << 2) + (ctrl_a[7] ? 19'(cfg_frame) : 19'(cfg_frame) << 1);
  end

  // state update for one command
  always_comb begin
    port_a_out_next = port_a_out; port_b_out_next = port_b_out;
    dir_a_next = dir_a; dir_b_next = dir_b;
    count_a_next = count_a; reload_a_next = reload_a;
    count_b_next = count_b; reload_b_next = reload_b;
    ctrl_a_next = ctrl_a; ctrl_b_next = ctrl_b; shift_reg_next = shift_reg;
    pending_next = pending_int; mask_next = int_mask;
    clock_next = clock_time; alarm_next = alarm_time; snap_next = snapshot_time;
    held_next = snapshot_held; halted_next = clock_halted;
    div_next = tenth_divider; tob_next = tob;
    rd = 8'h00;
    ua = 1'b0; ub = 1'b0; cntb = 1'b0;
    s8 = 8'h00; m8 = 8'h00; h8 = 8'h00; pm = 8'h00; tplus = 5'd0;
    alarm_sel = ctrl_b[7];
    if (q_cmd.is_read) begin
      case (it.reg_addr)
        R_PRA, R_PRB: rd = 8'h00;
        R_DDRA: rd = dir_a;
        R_DDRB: rd = dir_b;
        R_TAL: rd = count_a[7:0];
        R_TAH: rd = count_a[15:8];
        R_TBL: rd = count_b[7:0];
        R_TBH: rd = count_b[15:8];
        R_TOD10: begin
          if (snapshot_held) begin
            rd = {4'd0, snapshot_time.tenths};
            if (it.side_effects) held_next = 1'b0;
          end else rd = {4'd0, clock_time.tenths};
        end
        R_TODS: rd = {1'b0, snapshot_held ? snapshot_time.sec : clock_time.sec};
        R_TODM: rd = {1'b0, snapshot_held ? snapshot_time.min : clock_time.min};
        R_TODH: begin
          if (it.side_effects && !snapshot_held) begin
            snap_next = clock_time;
            held_next = 1'b1;
            rd = clock_time.hour;
          end else rd = snapshot_held ? snapshot_time.hour : clock_time.hour;
        end
        R_SDR: rd = shift_reg;
        R_ICR: begin
          rd = {|(pending_int & int_mask), 2'b00, pending_int};
          if (it.side_effects) pending_next = 5'd0;
        end
        R_CRA: rd = ctrl_a & 8'hEF;
        default: rd = ctrl_b & 8'hEF;
      endcase
    end else if (q_cmd.is_write) begin
      case (it.reg_addr)
        R_PRA: port_a_out_next = it.write_data;
        R_PRB: port_b_out_next = it.write_data;
        R_DDRA: dir_a_next = it.write_data;
        R_DDRB: dir_b_next = it.write_data;
        R_TAL: reload_a_next = {reload_a[15:8], it.write_data};
        R_TAH: begin
          reload_a_next = {it.write_data, reload_a[7:0]};
          if (!ctrl_a[0]) count_a_next = reload_a_next;
        end
        R_TBL: reload_b_next = {reload_b[15:8], it.write_data};
        R_TBH: begin
          reload_b_next = {it.write_data, reload_b[7:0]};
          if (!ctrl_b[0]) count_b_next = reload_b_next;
        end
        R_TOD10: begin
          if (alarm_sel) alarm_next.tenths = it.write_data[3:0];
          else begin
            clock_next.tenths = it.write_data[3:0];
            halted_next = 1'b0;
          end
        end
        R_TODS: begin
          if (alarm_sel) alarm_next.sec = it.write_data[6:0];
          else clock_next.sec = it.write_data[6:0];
        end
        R_TODM: begin
          if (alarm_sel) alarm_next.min = it.write_data[6:0];
          else clock_next.min = it.write_data[6:0];
        end
        R_TODH: begin
          if (alarm_sel) alarm_next.hour = it.write_data & 8'h9F;
          else begin
            clock_next.hour = it.write_data & 8'h9F;
            halted_next = 1'b1;
          end
        end
        R_SDR: shift_reg_next = it.write_data;
        R_ICR: begin
          if (it.write_data[7]) mask_next = int_mask | it.write_data[4:0];
          else mask_next = int_mask & ~it.write_data[4:0];
        end
        R_CRA: begin
          if (it.write_data[4]) count_a_next = reload_a;
          ctrl_a_next = it.write_data & 8'hEF;
        end
        default: begin
          if (it.write_data[4]) count_b_next = reload_b;
          ctrl_b_next = it.write_data & 8'hEF;
        end
      endcase
    end else if (q_cmd.is_tick) begin
      // timers
      tob_next = {2'b00, tob[1:0]};
      if (ctrl_a[0] && !ctrl_a[5]) begin
        if (count_a == 16'd0) begin
          count_a_next = reload_a;
          ua = 1'b1;
        end else count_a_next = count_a - 16'd1;
      end
      if (ua) begin
        pending_next[0] = 1'b1;
        if (ctrl_a[2]) tob_next[0] = ~tob_next[0];
        else tob_next[2] = 1'b1;
        if (ctrl_a[3]) ctrl_a_next[0] = 1'b0;
      end
      if (ctrl_b[0]) begin
        cntb = (ctrl_b[6:5] == 2'd0) || ((ctrl_b[6:5] == 2'd2) && ua);
        if (cntb) begin
          if (count_b == 16'd0) begin
            count_b_next = reload_b;
            ub = 1'b1;
          end else count_b_next = count_b - 16'd1;
        end
      end
      if (ub) begin
        pending_next[1] = 1'b1;
        if (ctrl_b[2]) tob_next[1] = ~tob_next[1];
        else tob_next[3] = 1'b1;
        if (ctrl_b[3]) ctrl_b_next[0] = 1'b0;
      end
      // time of day
      div_next = tenth_divider + 19'd1;
      if (div_next >= period) begin
        div_next = div_next - period;
        if (!clock_halted) begin
          tplus = {1'b0, clock_time.tenths} + 5'd1;
          if (tplus > 5'd9) begin
            clock_next.tenths = 4'd0;
            s8 = bcd_next({1'b0, clock_time.sec}, 8'h59);
            clock_next.sec = s8[6:0];
            if (s8 == 8'h00) begin
              m8 = bcd_next({1'b0, clock_time.min}, 8'h59);
              clock_next.min = m8[6:0];
              if (m8 == 8'h00) begin
                pm = clock_time.hour & 8'h80;
                h8 = bcd_next(clock_time.hour & 8'h1F, 8'h99);
                if (h8 == 8'h12) pm = pm ^ 8'h80;
                else if (h8 > 8'h12) h8 = 8'h01;
                clock_next.hour = h8 | pm;
              end
            end
          end else clock_next.tenths = tplus[3:0];
          if (clock_next == alarm_time) pending_next[2] = 1'b1;
        end
      end
    end
  end

  // pins from the state after the step; all pins are worked out from the new values
  logic [7:0] da, db, pa, pb, lowrows;
  always_comb begin
    da = (port_a_out_next & dir_a_next) | ~dir_a_next;
    db = (port_b_out_next & dir_b_next) | ~dir_b_next;
    pa = da & it.port_a_external;
    pb = db;
    lowrows = ~db;
    if (cfg_kbd) begin
      pa = pa & it.joystick_two;
      pb = pb & it.joystick_one;
      for (int c = 0; c < 8; c++) begin
        if ((~it.keyboard_matrix[8*c +: 8] & lowrows) != 8'h00) pa[c] = 1'b0;
        if (!da[c]) pb = pb & it.keyboard_matrix[8*c +: 8];
      end
    end
    if (ctrl_a_next[1]) pb[6] = ctrl_a_next[2] ? tob_next[0] : tob_next[2];
    if (ctrl_b_next[1]) pb[7] = ctrl_b_next[2] ? tob_next[1] : tob_next[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      port_a_out <= 8'h00; port_b_out <= 8'h00; dir_a <= 8'h00; dir_b <= 8'h00;
      count_a <= 16'hFFFF; reload_a <= 16'hFFFF; count_b <= 16'hFFFF; reload_b <= 16'hFFFF;
      ctrl_a <= 8'h00; ctrl_b <= 8'h00; shift_reg <= 8'h00;
      pending_int <= 5'd0; int_mask <= 5'd0;
      clock_time <= '{tenths: 4'd0, sec: 7'd0, min: 7'd0, hour: 8'h01};
      snapshot_time <= '{tenths: 4'd0, sec: 7'd0, min: 7'd0, hour: 8'h01};
      alarm_time <= '0;
      snapshot_held <= 1'b0; clock_halted <= 1'b1;
      tenth_divider <= 19'd0; tob <= 4'd0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (go) begin
        out_valid <= 1'b1;
        port_a_out <= port_a_out_next; port_b_out <= port_b_out_next;
        dir_a <= dir_a_next; dir_b <= dir_b_next;
        count_a <= count_a_next; reload_a <= reload_a_next;
        count_b <= count_b_next; reload_b <= reload_b_next;
        ctrl_a <= ctrl_a_next; ctrl_b <= ctrl_b_next; shift_reg <= shift_reg_next;
        pending_int <= pending_next; int_mask <= mask_next;
        clock_time <= clock_next; alarm_time <= alarm_next; snapshot_time <= snap_next;
        snapshot_held <= held_next; clock_halted <= halted_next;
        tenth_divider <= div_next; tob <= tob_next;
      end
    end
    if (go) begin
      out_res.read_data <= (q_cmd.is_read && it.reg_addr == R_PRA) ? pa :
                           (q_cmd.is_read && it.reg_addr == R_PRB) ? pb : rd;
      out_res.irq <= |(pending_next & mask_next);
      out_res.port_a_pins <= pa;
      out_res.port_b_pins <= pb;
      out_res.video_bank <= ~da[1:0];
    end
  end
endmodule

// ===== hdl/interface_adapter_timers_tod.sv =====
// Channel | Dir | Payload
// in_ch   | in  | func, reg_addr, write_data, side_effects, keyboard_matrix, joysticks, port A
// out_ch  | out | read_data, irq, port_a_pins, port_b_pins, video_bank
// apb     | in  | is_keyboard_unit (0x0), cycles_per_frame (0x4)
// One beat per clock unless a side stalls: a two-entry queue feeds the execute stage,
// which holds all state and registers its update together with the result.
// The tenths period (5 or 6 frames) is worked out each cycle from the frame
// length and the control bit. Reset is synchronous; the output register and
// queue let either side stall without loss.
`include "assert_macros.svh"
module interface_adapter_timers_tod import iat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  iat_stream_if.sink   in_ch,
  iat_stream_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic        cfg_kbd;
  logic [15:0] cfg_frame;
  logic        q_valid, q_ready, cfg_we;
  cmd_t        q_cmd;
  result_t     res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_kbd <= 1'b1;
      cfg_frame <= FRAME_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == CFG_FRAME[0]) cfg_frame <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
      else cfg_kbd <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == CFG_KBD[0]) prdata = {31'd0, cfg_kbd};
    else prdata = {16'd0, cfg_frame};
  end

  iat_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(item_t'(in_ch.data)),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  iat_back u_back (
    .clk(clk), .rst(rst), .cfg_kbd(cfg_kbd), .cfg_frame(cfg_frame),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );

  assign out_ch.data = res;

  `CHK_NEXT(a_out_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
  `CHK_IMPL(a_no_issue_blocked, clk, rst, out_ch.valid && !out_ch.ready, !q_ready)
  `CHK_IMPL(a_pready, clk, rst, 1'b1, pready)
endmodule

// ===== tb/tb_interface_adapter_timers_tod.sv =====
`timescale 1ns / 100ps

module tb_interface_adapter_timers_tod;
  import iat_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] t;
    logic [7:0] s;
    logic [7:0] m;
    logic [7:0] h;
  } daytime_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  iat_stream_if #(.W($bits(item_t)))   in_ch();
  iat_stream_if #(.W($bits(result_t))) out_ch();

  interface_adapter_timers_tod dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // predicted state of the adapter
  logic        kbd_wired;
  logic [15:0] frame_len;
  logic [7:0]  pa_out, pb_out, ddra, ddrb, cra, crb, sdr;
  logic [15:0] cnt_a, latch_a, cnt_b, latch_b;
  logic [4:0]  icr_pend, icr_mask;
  daytime_t    tod, alarm, snap;
  logic        snap_held, tod_halted;
  int unsigned tenth_div;
  logic [3:0]  tmr_out;

  result_t pending_results[$];
  int      errors = 0;
  int      beats_sent = 0;
  int      beats_checked = 0;
  int      burst_left = 0;

  function automatic void adapter_reset();
    kbd_wired = 1'b1;
    frame_len = FRAME_RESET;
    pa_out = '0; pb_out = '0; ddra = '0; ddrb = '0;
    cnt_a = 16'hFFFF; latch_a = 16'hFFFF; cnt_b = 16'hFFFF; latch_b = 16'hFFFF;
    cra = '0; crb = '0; icr_pend = '0; icr_mask = '0; sdr = '0;
    tod = '{8'h00, 8'h00, 8'h00, 8'h01};
    alarm = '{8'h00, 8'h00, 8'h00, 8'h00};
    snap = tod;
    snap_held = 1'b0;
    tod_halted = 1'b1;
    tenth_div = 0;
    tmr_out = '0;
  endfunction

  function automatic logic [7:0] drive_a();
    return (pa_out & ddra) | ~ddra;
  endfunction

  function automatic logic [7:0] drive_b();
    return (pb_out & ddrb) | ~ddrb;
  endfunction

  function automatic logic [7:0] pins_a(item_t it);
    logic [7:0] v;
    logic [7:0] low_rows;
    v = drive_a() & it.port_a_external;
    if (kbd_wired) begin
      low_rows = ~drive_b();
      v &= it.joystick_two;
      for (int c = 0; c < 8; c++)
        if ((~it.keyboard_matrix[8*c +: 8] & low_rows) != 0) v[c] = 1'b0;
    end
    return v;
  endfunction

  function automatic logic [7:0] pins_b(item_t it);
    logic [7:0] v;
    logic [7:0] da;
    v = drive_b();
    if (kbd_wired) begin
      da = drive_a();
      v &= it.joystick_one;
      for (int c = 0; c < 8; c++)
        if (!da[c]) v &= it.keyboard_matrix[8*c +: 8];
    end
    if (cra[1]) v[6] = cra[2] ? tmr_out[0] : tmr_out[2];
    if (crb[1]) v[7] = crb[2] ? tmr_out[1] : tmr_out[3];
    return v;
  endfunction

  // BCD increment digit by digit, wrapping to zero above the field limit
  function automatic logic [7:0] bcd_step(logic [7:0] v, logic [7:0] lim);
    logic [4:0] lo;
    logic [4:0] hi;
    logic [7:0] r;
    lo = {1'b0, v[3:0]} + 5'd1;
    hi = {1'b0, v[7:4]};
    if (lo > 5'd9) begin
      lo = 5'd0;
      hi = hi + 5'd1;
    end
    r = {hi[3:0], lo[3:0]};
    return (r > lim) ? 8'h00 : r;
  endfunction

  function automatic void run_timers();
    logic ua;
    logic ub;
    logic cnt;
    ua = 1'b0; ub = 1'b0; cnt = 1'b0;
    tmr_out &= 4'b0011;
    if (cra[0] && !cra[5]) begin
      if (cnt_a == 0) begin
        cnt_a = latch_a;
        ua = 1'b1;
      end else cnt_a--;
    end
    if (ua) begin
      icr_pend[0] = 1'b1;
      if (cra[2]) tmr_out[0] = ~tmr_out[0];
      else tmr_out[2] = 1'b1;
      if (cra[3]) cra[0] = 1'b0;
    end
    if (crb[0]) begin
      case (crb[6:5])
        2'd0: cnt = 1'b1;
        2'd2: cnt = ua;
        default: cnt = 1'b0;
      endcase
      if (cnt) begin
        if (cnt_b == 0) begin
          cnt_b = latch_b;
          ub = 1'b1;
        end else cnt_b--;
      end
    end
    if (ub) begin
      icr_pend[1] = 1'b1;
      if (crb[2]) tmr_out[1] = ~tmr_out[1];
      else tmr_out[3] = 1'b1;
      if (crb[3]) crb[0] = 1'b0;
    end
  endfunction

  function automatic void run_clock();
    int unsigned period;
    logic [7:0]  pm;
    logic [7:0]  hr;
    period = (cra[7] ? 5 : 6) * frame_len;
    tenth_div++;
    if (tenth_div < period) return;
    tenth_div -= period;
    if (tod_halted) return;
    if (tod.t + 1 > 9) begin
      tod.t = 8'h00;
      tod.s = bcd_step(tod.s, 8'h59);
      if (tod.s == 0) begin
        tod.m = bcd_step(tod.m, 8'h59);
        if (tod.m == 0) begin
          pm = tod.h & 8'h80;
          hr = bcd_step(tod.h & 8'h1F, 8'h99);
          if (hr == 8'h12) pm ^= 8'h80;
          else if (hr > 8'h12) hr = 8'h01;
          tod.h = hr | pm;
        end
      end
    end else tod.t = tod.t + 8'd1;
    if (tod == alarm) icr_pend[2] = 1'b1;
  endfunction

  function automatic logic [7:0] reg_read(item_t it);
    logic [7:0] v;
    logic       fx;
    fx = it.side_effects;
    case (it.reg_addr)
      R_PRA:  return pins_a(it);
      R_PRB:  return pins_b(it);
      R_DDRA: return ddra;
      R_DDRB: return ddrb;
      R_TAL:  return cnt_a[7:0];
      R_TAH:  return cnt_a[15:8];
      R_TBL:  return cnt_b[7:0];
      R_TBH:  return cnt_b[15:8];
      R_TOD10: begin
        if (snap_held) begin
          if (fx) snap_held = 1'b0;
          return snap.t;
        end
        return tod.t;
      end
      R_TODS: return snap_held ? snap.s : tod.s;
      R_TODM: return snap_held ? snap.m : tod.m;
      R_TODH: begin
        if (fx && !snap_held) begin
          snap = tod;
          snap_held = 1'b1;
        end
        return snap_held ? snap.h : tod.h;
      end
      R_SDR: return sdr;
      R_ICR: begin
        v = {3'b000, icr_pend};
        if ((icr_pend & icr_mask) != 0) v[7] = 1'b1;
        if (fx) icr_pend = '0;
        return v;
      end
      R_CRA: return cra & ~8'h10;
      default: return crb & ~8'h10;
    endcase
  endfunction

  function automatic void reg_write(logic [3:0] ra, logic [7:0] v);
    logic to_alarm;
    to_alarm = crb[7];
    case (ra)
      R_PRA:  pa_out = v;
      R_PRB:  pb_out = v;
      R_DDRA: ddra = v;
      R_DDRB: ddrb = v;
      R_TAL:  latch_a[7:0] = v;
      R_TAH: begin
        latch_a[15:8] = v;
        if (!cra[0]) cnt_a = latch_a;
      end
      R_TBL:  latch_b[7:0] = v;
      R_TBH: begin
        latch_b[15:8] = v;
        if (!crb[0]) cnt_b = latch_b;
      end
      R_TOD10: begin
        if (to_alarm) alarm.t = v & 8'h0F;
        else begin
          tod.t = v & 8'h0F;
          tod_halted = 1'b0;
        end
      end
      R_TODS: if (to_alarm) alarm.s = v & 8'h7F; else tod.s = v & 8'h7F;
      R_TODM: if (to_alarm) alarm.m = v & 8'h7F; else tod.m = v & 8'h7F;
      R_TODH: begin
        if (to_alarm) alarm.h = v & 8'h9F;
        else begin
          tod.h = v & 8'h9F;
          tod_halted = 1'b1;
        end
      end
      R_SDR: sdr = v;
      R_ICR: begin
        if (v[7]) icr_mask = icr_mask | v[4:0];
        else icr_mask = icr_mask & ~v[4:0];
      end
      R_CRA: begin
        if (v[4]) cnt_a = latch_a;
        cra = v & ~8'h10;
      end
      default: begin
        if (v[4]) cnt_b = latch_b;
        crb = v & ~8'h10;
      end
    endcase
  endfunction

  function automatic result_t adapter_step(item_t it);
    result_t r;
    logic [7:0] rd;
    logic [7:0] da;
    rd = '0;
    case (it.func)
      FUNC_READ:  rd = reg_read(it);
      FUNC_WRITE: reg_write(it.reg_addr, it.write_data);
      FUNC_TICK: begin
        run_timers();
        run_clock();
      end
      default: ;
    endcase
    da = drive_a();
    r.read_data   = rd;
    r.irq         = (icr_pend & icr_mask) != 0;
    r.port_a_pins = pins_a(it);
    r.port_b_pins = pins_b(it);
    r.video_bank  = ~da[1:0];
    return r;
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch on beat %0d: %s got %h want %h", beats_checked, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        $display("result beat with nothing outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.read_data != want.read_data) report("read_data", got.read_data, want.read_data);
        if (got.irq != want.irq) report("irq", got.irq, want.irq);
        if (got.port_a_pins != want.port_a_pins)
          report("port_a_pins", got.port_a_pins, want.port_a_pins);
        if (got.port_b_pins != want.port_b_pins)
          report("port_b_pins", got.port_b_pins, want.port_b_pins);
        if (got.video_bank != want.video_bank)
          report("video_bank", got.video_bank, want.video_bank);
      end
      beats_checked++;
    end
  end

  // receiver stalls: ready follows one of four random patterns, redrawn periodically
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // one beat in; bursts of random length with gaps between
  task automatic send_beat(item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(adapter_step(it));
    beats_sent++;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 8);
    end else burst_left--;
  endtask

  function automatic item_t make_item(logic [1:0] f, logic [3:0] ra, logic [7:0] wd,
                                      logic fx);
    item_t it;
    it.func = f;
    it.reg_addr = ra;
    it.write_data = wd;
    it.side_effects = fx;
    if ($urandom_range(0, 2) == 0) it.keyboard_matrix = {$urandom(), $urandom()};
    else begin
      it.keyboard_matrix = '1;
      it.keyboard_matrix[$urandom_range(0, 63)] = 1'b0;
    end
    it.joystick_one = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom());
    it.joystick_two = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom());
    it.port_a_external = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom());
    return it;
  endfunction

  task automatic wr(logic [3:0] ra, logic [7:0] v);
    send_beat(make_item(FUNC_WRITE, ra, v, 1'b0));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx[0], 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == CFG_KBD) kbd_wired = v[0];
    else frame_len = (v[15:0] == 0) ? 16'd1 : v[15:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // boundary-heavy BCD value
  function automatic logic [7:0] bcd_pick();
    case ($urandom_range(0, 5))
      0: return 8'h59;
      1: return 8'h58;
      2: return 8'h7F;
      3: return 8'h09;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    for (int r = 0; r < 16; r++) send_beat(make_item(FUNC_READ, 4'(r), 8'h00, 1'b1));
    wr(R_DDRA, 8'hFF);
    wr(R_PRA, 8'hAA);
    wr(R_DDRB, 8'hFF);
    wr(R_PRB, 8'h00);
    begin
      item_t it;
      it = make_item(FUNC_READ, R_PRA, 8'h00, 1'b0);
      it.keyboard_matrix = '0;
      send_beat(it);
      wr(R_DDRA, 8'h00);
      it = make_item(FUNC_READ, R_PRB, 8'h00, 1'b0);
      it.keyboard_matrix = '0;
      it.joystick_one = 8'h00;
      send_beat(it);
    end
    send_beat(make_item(FUNC_UNUSED, R_ICR, 8'hFF, 1'b1));
    wr(R_ICR, 8'h9F);
    send_beat(make_item(FUNC_READ, R_ICR, 8'h00, 1'b0));
  endtask

  // timer programming followed by ticks and reads
  task automatic test_timers(int budget);
    int stop;
    stop = beats_sent + budget;
    while (beats_sent < stop) begin
      if ($urandom_range(0, 5) == 0) begin
        wr(R_TAL, 8'($urandom())); wr(R_TAH, 8'($urandom()));
      end else begin
        wr(R_TAL, 8'($urandom_range(0, 12))); wr(R_TAH, 8'h00);
      end
      wr(R_TBL, 8'($urandom_range(0, 6))); wr(R_TBH, 8'h00);
      wr(R_ICR, 8'($urandom()));
      wr(R_CRA, 8'($urandom()) | 8'h01);
      wr(R_CRB, 8'($urandom()) | 8'h01);
      repeat ($urandom_range(4, 40)) begin
        case ($urandom_range(0, 4))
          0: send_beat(make_item(FUNC_READ, 4'($urandom_range(0, 15)), 8'h00,
                                 1'($urandom())));
          1: send_beat(make_item(FUNC_READ, R_ICR, 8'h00, 1'($urandom())));
          default: send_beat(make_item(FUNC_TICK, 4'($urandom()), 8'($urandom()),
                                       1'($urandom())));
        endcase
      end
    end
  endtask

  // time-of-day and alarm programming, ticks and latched reads
  task automatic test_tod(int budget);
    int stop;
    stop = beats_sent + budget;
    while (beats_sent < stop) begin
      if ($urandom_range(0, 1) != 0) begin
        wr(R_CRB, 8'h80);
        wr(R_TODH, ($urandom_range(0, 1) != 0) ? 8'h01 : 8'($urandom()));
        wr(R_TODM, bcd_pick());
        wr(R_TODS, bcd_pick());
        wr(R_TOD10, 8'($urandom_range(0, 15)));
        wr(R_CRB, 8'h00);
      end
      wr(R_ICR, 8'h84);
      if ($urandom_range(0, 2) == 0) wr(R_CRA, 8'($urandom()) & 8'hF6);
      case ($urandom_range(0, 4))
        0: wr(R_TODH, 8'h12);
        1: wr(R_TODH, 8'h92);
        2: wr(R_TODH, 8'h11);
        3: wr(R_TODH, 8'h1F);
        default: wr(R_TODH, 8'($urandom()));
      endcase
      wr(R_TODM, bcd_pick());
      wr(R_TODS, bcd_pick());
      wr(R_TOD10, 8'($urandom_range(0, 15)));
      repeat ($urandom_range(10, 60)) begin
        if ($urandom_range(0, 3) == 0)
          send_beat(make_item(FUNC_READ, 4'($urandom_range(8, 13)), 8'h00, 1'($urandom())));
        else send_beat(make_item(FUNC_TICK, 4'h0, 8'h00, 1'b0));
      end
    end
  endtask

  task automatic test_noise(int budget);
    repeat (budget)
      send_beat(make_item(2'($urandom()), 4'($urandom()), 8'($urandom()), 1'($urandom())));
  endtask

  initial begin
    adapter_reset();
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    settle();
    apb_write(CFG_KBD, 32'd0);
    apb_write(CFG_FRAME, 32'd1);
    test_timers(300);
    test_tod(300);
    settle();
    apb_write(CFG_KBD, 32'd1);
    apb_write(CFG_FRAME, 32'd0);
    test_tod(250);
    test_noise(150);
    settle();
    apb_write(CFG_FRAME, 32'd65535);
    test_timers(200);
    test_noise(100);
    settle();
    apb_write(CFG_KBD, 32'd0);
    apb_write(CFG_FRAME, 32'($urandom_range(2, 7)));
    test_tod(300);
    test_noise(200);
    settle();
    repeat (10) @(posedge clk);
    $display("covered %0d beats over timers, time of day, ports and noise", beats_sent);
    $display("frame lengths 1, 0, 65535 and small, both port wirings; %0d results checked",
             beats_checked);
    if (errors == 0 && pending_results.size() == 0)
      $display("tb_interface_adapter_timers_tod passed");
    else
      $display("tb_interface_adapter_timers_tod failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_interface_adapter_timers_tod failed");
    $finish;
  end

endmodule

// ===== interface_adapter_timers_tod.f =====
+incdir+hdl
hdl/iat_pkg.sv
hdl/iat_stream_if.sv
hdl/iat_front.sv
hdl/iat_back.sv
hdl/interface_adapter_timers_tod.sv
tb/tb_interface_adapter_timers_tod.sv
